// File: design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Pixel beat types, fixed point constants and pipeline depth for the HSV to
// RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W       = 15;
  localparam int FRAC_W      = 9;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;

  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_SECTOR  = 60 << HUE_FRAC_BITS;
  localparam int HUE_MOD     = 6 * HUE_SECTOR;
  localparam int HUE_MAX     = (1 << HUE_W) - 1;

  localparam int X_W         = $clog2(5 * HUE_SECTOR + HUE_MAX + 1);
  localparam int K_W         = $clog2(HUE_SECTOR + 1);
  localparam int PROD_W      = FRAC_W + K_W;
  localparam int FULL_SCALE  = 256 * HUE_SECTOR;
  localparam int DIFF_W      = $clog2(FULL_SCALE + 1);
  localparam int P_W         = FRAC_W + DIFF_W;
  localparam int M_W         = P_W + 5;
  localparam int SCALE_SHIFT = 18 + HUE_FRAC_BITS;

  localparam int CH_N [NUM_CHAN] = '{5, 3, 1};

  localparam int PIPE_DEPTH  = 5;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] brightness;
    logic [CHAN_W-1:0] alpha_in;
  } hsv_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha_out;
  } rgb_pixel_t;

endpackage

// File: design/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top: HSV to 8-bit RGB pixel converter
// Each accepted beat passes through five stages to its done strobe.
// Throughput: one pixel per clock; busy is high only during reset.
// Reset clears the stage valid bits; beats in flight are dropped.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  hsv_pixel_t pixel_in,
  output logic       done,
  output rgb_pixel_t pixel_out
);

  localparam logic [X_W-1:0]    MOD_X   = X_W'(HUE_MOD);
  localparam logic [X_W-1:0]    SEC_X   = X_W'(HUE_SECTOR);
  localparam logic [X_W-1:0]    SEC2_X  = X_W'(2 * HUE_SECTOR);
  localparam logic [X_W-1:0]    SEC4_X  = X_W'(4 * HUE_SECTOR);
  localparam logic [PROD_W-1:0] FULL_P  = PROD_W'(FULL_SCALE);
  localparam logic [M_W-1:0]    CLIP_M  = M_W'(256) << SCALE_SHIFT;

  logic [PIPE_DEPTH-1:0] valid;

  logic [X_W-1:0]    x1      [NUM_CHAN];
  logic [X_W-1:0]    x1_next [NUM_CHAN];
  logic [FRAC_W-1:0] sat1, val1;
  logic [CHAN_W-1:0] alpha1;

  logic [K_W-1:0]    k2      [NUM_CHAN];
  logic [K_W-1:0]    k2_next [NUM_CHAN];
  logic [FRAC_W-1:0] sat2, val2;
  logic [CHAN_W-1:0] alpha2;

  logic [DIFF_W-1:0] diff3      [NUM_CHAN];
  logic [DIFF_W-1:0] diff3_next [NUM_CHAN];
  logic [FRAC_W-1:0] val3;
  logic [CHAN_W-1:0] alpha3;

  logic [P_W-1:0]    p4      [NUM_CHAN];
  logic [P_W-1:0]    p4_next [NUM_CHAN];
  logic [CHAN_W-1:0] alpha4;

  logic [CHAN_W-1:0] q5_next [NUM_CHAN];

  assign busy = rst;
  assign done = valid[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[PIPE_DEPTH-2:0], start};
    end
  end

  always_comb begin
    logic [X_W-1:0] x;
    for (int c = 0; c < NUM_CHAN; c++) begin
      x = X_W'(pixel_in.hue) + X_W'(CH_N[c] * HUE_SECTOR);
      x1_next[c] = (x >= MOD_X) ? x - MOD_X : x;
    end
  end

  always_comb begin
    logic [X_W-1:0] kk;
    logic [X_W-1:0] kf;
    for (int c = 0; c < NUM_CHAN; c++) begin
      kk = (x1[c] >= MOD_X) ? x1[c] - MOD_X : x1[c];
      if (kk >= SEC4_X) begin
        kf = '0;
      end else if (kk >= SEC2_X) begin
        kf = SEC4_X - kk;
      end else begin
        kf = kk;
      end
      k2_next[c] = (kf > SEC_X) ? K_W'(SEC_X) : kf[K_W-1:0];
    end
  end

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod = PROD_W'(sat2) * PROD_W'(k2[c]);
      diff3_next[c] = (prod < FULL_P) ? DIFF_W'(FULL_P - prod) : '0;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      p4_next[c] = P_W'(val3) * P_W'(diff3[c]);
    end
  end

  always_comb begin
    logic [M_W-1:0] m;
    for (int c = 0; c < NUM_CHAN; c++) begin
      m = (M_W'(p4[c]) << 4) + M_W'(p4[c]);
      q5_next[c] = (m >= CLIP_M) ? {CHAN_W{1'b1}} : CHAN_W'(m >> SCALE_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    x1     <= x1_next;
    sat1   <= pixel_in.saturation;
    val1   <= pixel_in.brightness;
    alpha1 <= pixel_in.alpha_in;

    k2     <= k2_next;
    sat2   <= sat1;
    val2   <= val1;
    alpha2 <= alpha1;

    diff3  <= diff3_next;
    val3   <= val2;
    alpha3 <= alpha2;

    p4     <= p4_next;
    alpha4 <= alpha3;

    pixel_out.red       <= q5_next[0];
    pixel_out.green     <= q5_next[1];
    pixel_out.blue      <= q5_next[2];
    pixel_out.alpha_out <= alpha4;
  end

endmodule

// File: design/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port level checks on beat timing and pixel relations of the converter.
// ----------------------------------------------------------------------------
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input hsv_pixel_t pixel_in,
  input logic       done,
  input rgb_pixel_t pixel_out
);

  a_beat_delivered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("accepted beat not delivered");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("done without an accepted beat");

  a_alpha_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> pixel_out.alpha_out == $past(pixel_in.alpha_in, PIPE_DEPTH))
    else $error("alpha mismatch");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    (done && $past(pixel_in.saturation, PIPE_DEPTH) == '0) |->
      (pixel_out.red == pixel_out.green && pixel_out.green == pixel_out.blue))
    else $error("zero saturation not gray");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && $past(pixel_in.brightness, PIPE_DEPTH) == '0) |->
      (pixel_out.red == '0 && pixel_out.green == '0 && pixel_out.blue == '0))
    else $error("zero value not black");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);
